@@ rtl/core/msrt_pkg.sv @@
// Shared types and constants for the merge sort engine.
package msrt_pkg;

    localparam int ELEM_W = 32;

    typedef logic signed [ELEM_W-1:0] elem_t;

endpackage

@@ rtl/core/msrt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module msrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/merge_sort_engine.sv @@
// Top level of the merge sort engine: loading, bottom-up merge passes and result output.
//
// Items are stored one per cycle until an item with final_element set arrives; items
// beyond MAX_ELEMENTS are dropped and every result of that batch then carries overflow.
// The set of n values is sorted in ceil(log2(n)) passes that ping-pong between two
// memories. Each pass starts in S_PASS and takes each pair of runs through S_PAIR,
// S_HEAD and S_MERGE, and S_MERGE writes one merged value per cycle. Each memory has
// one registered read port. The sorted values then leave one at a time through
// S_OUT_RD and S_OUT_WAIT, held while out_ready is low. No input item is accepted
// during sorting or output.
module merge_sort_engine
    import msrt_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  elem_t element,
    input  logic  final_element,
    output logic  out_valid,
    input  logic  out_ready,
    output elem_t sorted_value,
    output logic  last_result,
    output logic  overflow
);

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W  = CNT_W + 1;
    localparam int SUM_W  = IDX_W + 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_PAIR,
        S_HEAD,
        S_MERGE,
        S_OUT_RD,
        S_OUT_WAIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                drop_reg, drop_next;
    logic                src_sel_reg, src_sel_next;
    logic [IDX_W-1:0]    width_reg, width_next;
    logic [IDX_W-1:0]    lo_reg, lo_next;
    logic [IDX_W-1:0]    mid_reg, mid_next;
    logic [IDX_W-1:0]    hi_reg, hi_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    elem_t               a_val_reg, a_val_next;
    elem_t               b_val_reg, b_val_next;
    logic                fill_a_reg, fill_a_next;
    logic                fill_b_reg, fill_b_next;
    logic                out_valid_reg, out_valid_next;
    elem_t               sorted_value_reg, sorted_value_next;
    logic                last_result_reg, last_result_next;
    logic                overflow_reg, overflow_next;

    logic [ADDR_W-1:0]   ram_raddr;
    logic [ADDR_W-1:0]   ram_waddr;
    elem_t               ram_wdata;
    logic                we0;
    logic                we1;
    elem_t               rdata0;
    elem_t               rdata1;
    elem_t               rdata;

    logic [IDX_W-1:0]    n_ext;
    logic [SUM_W-1:0]    lo_plus_w;
    logic [SUM_W-1:0]    lo_plus_2w;
    elem_t               cur_a;
    elem_t               cur_b;
    logic                a_ok;
    logic                b_ok;
    logic                take_a;
    logic                out_last;

    msrt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram0 (
        .clk   (clk),
        .we    (we0),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata0)
    );

    msrt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata1)
    );

    assign rdata      = src_sel_reg ? rdata1 : rdata0;
    assign n_ext      = IDX_W'(count_reg);
    assign lo_plus_w  = SUM_W'(lo_reg) + SUM_W'(width_reg);
    assign lo_plus_2w = SUM_W'(lo_reg) + {width_reg, 1'b0};
    assign cur_a      = fill_a_reg ? rdata : a_val_reg;
    assign cur_b      = fill_b_reg ? rdata : b_val_reg;
    assign a_ok       = i_reg < mid_reg;
    assign b_ok       = j_reg < hi_reg;
    assign take_a     = a_ok && (!b_ok || (cur_a < cur_b));
    assign out_last   = (k_reg + IDX_W'(1)) == n_ext;

    assign in_ready     = (state_reg == S_LOAD);
    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign last_result  = last_result_reg;
    assign overflow     = overflow_reg;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        drop_next         = drop_reg;
        src_sel_next      = src_sel_reg;
        width_next        = width_reg;
        lo_next           = lo_reg;
        mid_next          = mid_reg;
        hi_next           = hi_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        a_val_next        = a_val_reg;
        b_val_next        = b_val_reg;
        fill_a_next       = fill_a_reg;
        fill_b_next       = fill_b_reg;
        sorted_value_next = sorted_value_reg;
        last_result_next  = last_result_reg;
        overflow_next     = overflow_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        ram_raddr         = k_reg[ADDR_W-1:0];
        ram_waddr         = k_reg[ADDR_W-1:0];
        ram_wdata         = take_a ? cur_a : cur_b;
        we0               = 1'b0;
        we1               = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                ram_waddr = count_reg[ADDR_W-1:0];
                ram_wdata = element;
                if (in_valid)
                begin
                    if (count_reg < CNT_W'(MAX_ELEMENTS))
                    begin
                        we0        = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (final_element)
                    begin
                        src_sel_next = 1'b0;
                        width_next   = IDX_W'(1);
                        state_next   = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                if (width_reg >= n_ext)
                begin
                    k_next     = '0;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = S_PAIR;
                end
            end
            S_PAIR:
            begin
                if (lo_reg >= n_ext)
                begin
                    width_next   = {width_reg[IDX_W-2:0], 1'b0};
                    src_sel_next = !src_sel_reg;
                    state_next   = S_PASS;
                end
                else
                begin
                    mid_next   = (lo_plus_w < SUM_W'(n_ext)) ? lo_plus_w[IDX_W-1:0] : n_ext;
                    hi_next    = (lo_plus_2w < SUM_W'(n_ext)) ? lo_plus_2w[IDX_W-1:0] : n_ext;
                    i_next     = lo_reg;
                    j_next     = (lo_plus_w < SUM_W'(n_ext)) ? lo_plus_w[IDX_W-1:0] : n_ext;
                    k_next     = lo_reg;
                    ram_raddr  = lo_reg[ADDR_W-1:0];
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                a_val_next  = rdata;
                ram_raddr   = j_reg[ADDR_W-1:0];
                fill_a_next = 1'b0;
                fill_b_next = 1'b1;
                state_next  = S_MERGE;
            end
            S_MERGE:
            begin
                a_val_next = cur_a;
                b_val_next = cur_b;
                if (k_reg == hi_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = S_PAIR;
                end
                else
                begin
                    we0    = src_sel_reg;
                    we1    = !src_sel_reg;
                    k_next = k_reg + IDX_W'(1);
                    if (take_a)
                    begin
                        i_next      = i_reg + IDX_W'(1);
                        ram_raddr   = i_next[ADDR_W-1:0];
                        fill_a_next = 1'b1;
                        fill_b_next = 1'b0;
                    end
                    else
                    begin
                        j_next      = j_reg + IDX_W'(1);
                        ram_raddr   = j_next[ADDR_W-1:0];
                        fill_a_next = 1'b0;
                        fill_b_next = 1'b1;
                    end
                end
            end
            S_OUT_RD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_OUT_WAIT;
                end
            end
            S_OUT_WAIT:
            begin
                out_valid_next    = 1'b1;
                sorted_value_next = rdata;
                last_result_next  = out_last;
                overflow_next     = drop_reg;
                if (out_last)
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                    state_next = S_LOAD;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            drop_reg         <= 1'b0;
            src_sel_reg      <= 1'b0;
            width_reg        <= '0;
            lo_reg           <= '0;
            mid_reg          <= '0;
            hi_reg           <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            a_val_reg        <= '0;
            b_val_reg        <= '0;
            fill_a_reg       <= 1'b0;
            fill_b_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            sorted_value_reg <= '0;
            last_result_reg  <= 1'b0;
            overflow_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            drop_reg         <= drop_next;
            src_sel_reg      <= src_sel_next;
            width_reg        <= width_next;
            lo_reg           <= lo_next;
            mid_reg          <= mid_next;
            hi_reg           <= hi_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            a_val_reg        <= a_val_next;
            b_val_reg        <= b_val_next;
            fill_a_reg       <= fill_a_next;
            fill_b_reg       <= fill_b_next;
            out_valid_reg    <= out_valid_next;
            sorted_value_reg <= sorted_value_next;
            last_result_reg  <= last_result_next;
            overflow_reg     <= overflow_next;
        end
    end

    // The buffer never holds more values than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("loaded count exceeds the buffer depth");

    // Every value written in a merge came from exactly one of the two runs.
    a_merge_balance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MERGE |-> (k_reg + mid_reg) == (i_reg + j_reg))
        else $error("merge indices out of step");

    // Neither run index moves past the end of its run.
    a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MERGE |-> (i_reg <= mid_reg) && (j_reg <= hi_reg))
        else $error("merge run index beyond its run");

    // The final result of a batch returns the block to loading with an empty buffer.
    a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT_WAIT && out_last)
        |=> (state_reg == S_LOAD) && (count_reg == '0) && last_result_reg && out_valid_reg)
        else $error("batch did not close after its final result");

endmodule

@@ dv/tb_top.sv @@
// Testbench for the merge sort engine: directed and random batches are loaded, predicted and checked.
`timescale 1ns / 100ps

module tb_top
    import msrt_pkg::*;
();

    localparam int DEPTH = 64;

    typedef struct packed {
        elem_t      value;
        logic       fin;
        logic [7:0] gap;
    } load_item_t;

    typedef struct packed {
        elem_t value;
        logic  last;
        logic  ovf;
    } sorted_result_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    elem_t element = '0;
    logic  final_element = 1'b0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    elem_t sorted_value;
    logic  last_result;
    logic  overflow;

    load_item_t     load_q[$];
    sorted_result_t sorted_q[$];
    elem_t          batch_q[$];
    logic           batch_dropped = 1'b0;

    int          item_count = 0;
    int          items_accepted = 0;
    int          results_seen = 0;
    int          errors = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    merge_sort_engine #(.MAX_ELEMENTS(DEPTH)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .element      (element),
        .final_element(final_element),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .overflow     (overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic elem_t draw_value();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return elem_t'($signed($urandom_range(0, 15)) - 8);
            default: return elem_t'($urandom);
        endcase
    endfunction

    function automatic void add_value(elem_t v, logic fin, logic quiet);
        load_item_t it;
        it.value = v;
        it.fin = fin;
        it.gap = quiet ? 8'd0 : 8'(draw_gap());
        load_q.push_back(it);
        item_count++;
    endfunction

    function automatic void add_batch(int n);
        logic quiet;
        quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
            add_value(draw_value(), i == n - 1, quiet);
    endfunction

    // Sorts the open batch and queues one expected result per stored value.
    function automatic void close_batch();
        elem_t          vals[DEPTH];
        elem_t          key;
        sorted_result_t res;
        int             n;
        int             j;
        n = batch_q.size();
        for (int i = 0; i < n; i++)
            vals[i] = batch_q[i];
        for (int i = 1; i < n; i++)
        begin
            key = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > key)
            begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = key;
        end
        for (int i = 0; i < n; i++)
        begin
            res.value = vals[i];
            res.last = (i == n - 1);
            res.ovf = batch_dropped;
            sorted_q.push_back(res);
        end
        batch_q.delete();
        batch_dropped = 1'b0;
    endfunction

    function automatic void load_value(elem_t v, logic fin);
        if (batch_q.size() < DEPTH)
            batch_q.push_back(v);
        else
            batch_dropped = 1'b1;
        if (fin)
            close_batch();
        items_accepted++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            element <= '0;
            final_element <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                load_value(element, final_element);
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (load_q.size() != 0)
                begin
                    element <= load_q[0].value;
                    final_element <= load_q[0].fin;
                    tx_gap <= load_q[0].gap;
                    in_valid <= 1'b1;
                    void'(load_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // A long hold-off on the output while the sender keeps offering items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= 70)
        begin
            hold_left <= 500;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_side
        sorted_result_t exp_res;
        int unsigned    nxt;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sorted_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual value %0d last %0b overflow %0b",
                             $time, sorted_value, last_result, overflow);
                    errors = errors + 1;
                end
                else
                begin
                    exp_res = sorted_q.pop_front();
                    if (sorted_value !== exp_res.value)
                    begin
                        $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                                 $time, exp_res.value, sorted_value);
                        errors = errors + 1;
                    end
                    if (last_result !== exp_res.last)
                    begin
                        $display("%0t: last_result mismatch: expected %0b, actual %0b",
                                 $time, exp_res.last, last_result);
                        errors = errors + 1;
                    end
                    if (overflow !== exp_res.ovf)
                    begin
                        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                                 $time, exp_res.ovf, overflow);
                        errors = errors + 1;
                    end
                end
                results_seen <= results_seen + 1;
                nxt = ((results_seen % 48) < 12) ? 0 : draw_gap();
            end
            else if (rx_gap != 0)
            begin
                nxt = rx_gap - 1;
            end
            else
            begin
                nxt = 0;
            end
            rx_gap <= nxt;
            out_ready <= (nxt == 0) && (hold_left == 0);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        add_value(32'sh8000_0000, 1'b1, 1'b0);
        add_value(32'sh7fff_ffff, 1'b1, 1'b1);
        add_value(32'sh7fff_ffff, 1'b0, 1'b0);
        add_value(32'sh8000_0000, 1'b0, 1'b0);
        add_value(32'sh0000_0000, 1'b0, 1'b0);
        add_value(-32'sd1, 1'b0, 1'b0);
        add_value(32'sd1, 1'b0, 1'b0);
        add_value(32'sh8000_0001, 1'b0, 1'b0);
        add_value(32'sh7fff_fffe, 1'b1, 1'b0);
        add_value(32'sd5, 1'b0, 1'b1);
        add_value(32'sd5, 1'b0, 1'b1);
        add_value(-32'sd3, 1'b0, 1'b1);
        add_value(32'sd5, 1'b0, 1'b1);
        add_value(-32'sd3, 1'b1, 1'b1);
        add_value(-32'sd2, 1'b0, 1'b0);
        add_value(-32'sd1, 1'b0, 1'b0);
        add_value(32'sd0, 1'b0, 1'b0);
        add_value(32'sd1, 1'b1, 1'b0);

        // A full buffer without loss, then a batch whose final item is dropped.
        add_batch(DEPTH);
        add_batch(DEPTH + $urandom_range(1, 4));
        while (item_count < 170)
        begin
            if ($urandom_range(0, 9) == 0)
                add_batch($urandom_range(DEPTH - 4, DEPTH + 6));
            else
                add_batch($urandom_range(1, 10));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < item_count || sorted_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/msrt_pkg.sv
rtl/core/msrt_ram.sv
rtl/core/merge_sort_engine.sv
dv/tb_top.sv
